@@ rtl/tds_from_adc_temp_compensated_top_assert.svh @@
// Assertion macros shared by the conversion pipeline modules.
// Each macro expects the using module to have ports named clock and reset.
`ifndef TDS_FROM_ADC_TEMP_COMPENSATED_TOP_ASSERT_SVH
`define TDS_FROM_ADC_TEMP_COMPENSATED_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define TDSADC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdsadc: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define TDSADC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdsadc: next-cycle check failed");

`endif

@@ rtl/tdsadc_pkg.sv @@
// Shared types and constants of the TDS conversion pipeline.
// Used by the front, divider, polynomial and top-level modules; depends on nothing.
package tdsadc_pkg;

   // Converter and field widths.
   localparam int ADC_W       = 10;
   localparam int ADC_BITS    = 10;
   localparam int TEMP_BITS   = 16;
   localparam int TDS_BITS    = 21;
   localparam int STATUS_BITS = 2;

   // Stream word layout.
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD     = RSP_TDATA_W - TDS_BITS - STATUS_BITS;

   // Voltage format: Q24 with three integer bits, saturated at 8.0.
   localparam int FRAC       = 24;
   localparam int V_INT_BITS = 3;
   localparam int Q_BITS     = FRAC + V_INT_BITS;
   localparam int V_BITS     = Q_BITS + 1;
   localparam int V2_BITS    = 2 * Q_BITS - FRAC + 1;
   localparam int V3_BITS    = 3 * Q_BITS - 2 * FRAC + 1;

   // Divider operands. The factor numerator N is at most 30 bits when positive.
   localparam int N_BITS       = 30;
   localparam int P_SCALE_BITS = 29;
   localparam int P_BITS       = ADC_BITS + P_SCALE_BITS;
   localparam int LOW_BITS     = ADC_BITS + V_INT_BITS;
   localparam int DIV_SHIFT    = FRAC - ADC_BITS;
   localparam int HEAD_EXT     = N_BITS + V_INT_BITS - P_SCALE_BITS;
   localparam int DIV_STAGES   = Q_BITS;
   localparam int TEMP_X_BITS  = TEMP_BITS + 1;

   // Sample scale: 5 V times the common denominator, or plain 5 without compensation.
   localparam logic [P_SCALE_BITS-1:0] P_SCALE_COMP = P_SCALE_BITS'(500000000);
   localparam logic [P_SCALE_BITS-1:0] P_SCALE_RAW  = P_SCALE_BITS'(5);

   // Factor numerators over a denominator of 1e8.
   localparam logic signed [TEMP_X_BITS-1:0] TEMP_F_ZERO = TEMP_X_BITS'(3200);
   localparam logic signed [TEMP_X_BITS-1:0] TEMP_C_OFS  = TEMP_X_BITS'(2500);
   localparam logic signed [N_BITS:0] F_SLOPE = (N_BITS + 1)'(11111);
   localparam logic signed [N_BITS:0] F_BASE  = (N_BITS + 1)'(50000000);
   localparam logic signed [N_BITS:0] C_SCALE = (N_BITS + 1)'(20000);
   localparam logic signed [N_BITS:0] N_ONE   = (N_BITS + 1)'(1);

   // Polynomial coefficients, one hundred times the cubic's terms.
   localparam logic [13:0] COEF3 = 14'(13342);
   localparam logic [14:0] COEF2 = 15'(25586);
   localparam logic [16:0] COEF1 = 17'(85739);
   localparam int T3_BITS  = V3_BITS + 14;
   localparam int T2_BITS  = V2_BITS + 15;
   localparam int T1_BITS  = V_BITS + 17;
   localparam int SUM_BITS = T3_BITS + 2;
   localparam int RES_BITS = SUM_BITS - FRAC - 1;

   localparam logic [V_BITS-1:0] V_SAT = {1'b1, {Q_BITS{1'b0}}};
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'd1 << FRAC);
   localparam logic signed [SUM_BITS-1:0] TRUNC_ADJ  =
      SUM_BITS'((64'd1 << (FRAC + 1)) - 64'd1);

   // Output limit.
   localparam logic signed [TDS_BITS-1:0] TDS_LIMIT = TDS_BITS'(999999);
   localparam logic signed [RES_BITS-1:0] LIMIT_RES = RES_BITS'(TDS_LIMIT);

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 2'd0,
      ST_CLAMP      = 2'd1,
      ST_BAD_FACTOR = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TEMP_COMP_EN = 1'b0,
      CSR_FAHRENHEIT   = 1'b1
   } csr_index_type;

   // Configuration as seen by the front stages.
   typedef struct packed {
      logic comp_en;
      logic fahrenheit;
   } cfg_type;

   // One word travelling through the divider stages.
   typedef struct packed {
      logic [N_BITS-1:0]   r;
      logic [N_BITS-1:0]   n;
      logic [LOW_BITS-1:0] p_low;
      logic [Q_BITS-1:0]   q;
      logic                sat;
      logic                bad;
   } div_word_type;

endpackage

@@ rtl/tdsadc_front.sv @@
// Front stages: compensation factor numerator, scaled sample and divider setup.
// Depends on tdsadc_pkg.
module tdsadc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  tdsadc_pkg::cfg_type                 cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [tdsadc_pkg::ADC_W-1:0]        adc_raw,
   input  logic signed [tdsadc_pkg::TEMP_BITS-1:0] water_temp,
   output logic                                out_valid,
   input  logic                                out_ready,
   output tdsadc_pkg::div_word_type            out_word
);

   logic signed [tdsadc_pkg::TEMP_X_BITS-1:0] temp_x;
   logic signed [tdsadc_pkg::TEMP_X_BITS-1:0] temp_f;
   logic signed [tdsadc_pkg::TEMP_X_BITS-1:0] temp_c;
   logic signed [tdsadc_pkg::N_BITS:0]        n_f;
   logic signed [tdsadc_pkg::N_BITS:0]        n_c;

   logic                                      a_valid_ff;
   logic signed [tdsadc_pkg::N_BITS:0]        a_n_ff;
   logic signed [tdsadc_pkg::N_BITS:0]        a_n_in;
   logic [tdsadc_pkg::P_BITS-1:0]             a_p_ff;
   logic [tdsadc_pkg::P_BITS-1:0]             a_p_in;

   logic                                      b_valid_ff;
   tdsadc_pkg::div_word_type                  b_word_ff;
   tdsadc_pkg::div_word_type                  b_word_in;
   logic [tdsadc_pkg::N_BITS-1:0]             n_mag;

   logic                                      rdy_a;
   logic                                      rdy_b;

   // A stage loads when it is empty or its word moves on.
   assign rdy_b    = !b_valid_ff || out_ready;
   assign rdy_a    = !a_valid_ff || rdy_b;
   assign in_ready = rdy_a;

   // Factor numerator over a common denominator of 1e8, and the scaled sample.
   assign temp_x = tdsadc_pkg::TEMP_X_BITS'(water_temp);
   assign temp_f = temp_x - tdsadc_pkg::TEMP_F_ZERO;
   assign temp_c = temp_x + tdsadc_pkg::TEMP_C_OFS;
   assign n_f    = temp_f * tdsadc_pkg::F_SLOPE + tdsadc_pkg::F_BASE;
   assign n_c    = temp_c * tdsadc_pkg::C_SCALE;

   always_comb begin
      if (cfg.comp_en) begin
         a_n_in = cfg.fahrenheit ? n_f : n_c;
         a_p_in = tdsadc_pkg::P_BITS'(adc_raw[tdsadc_pkg::ADC_BITS-1:0])
                  * tdsadc_pkg::P_SCALE_COMP;
      end else begin
         a_n_in = tdsadc_pkg::N_ONE;
         a_p_in = tdsadc_pkg::P_BITS'(adc_raw[tdsadc_pkg::ADC_BITS-1:0])
                  * tdsadc_pkg::P_SCALE_RAW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (rdy_a) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_n_ff <= a_n_in;
         a_p_ff <= a_p_in;
      end
   end

   // Flag a factor that is not positive, detect a quotient of 8.0 or more,
   // and seed the remainder with the top bits of the sample.
   assign n_mag = a_n_ff[tdsadc_pkg::N_BITS-1:0];

   always_comb begin
      b_word_in.bad   = a_n_ff[tdsadc_pkg::N_BITS] || (a_n_ff == '0);
      b_word_in.sat   = {{tdsadc_pkg::HEAD_EXT{1'b0}}, a_p_ff} >=
                        {n_mag, {tdsadc_pkg::LOW_BITS{1'b0}}};
      b_word_in.r     = {{tdsadc_pkg::HEAD_EXT{1'b0}},
                         a_p_ff[tdsadc_pkg::P_BITS-1:tdsadc_pkg::LOW_BITS]};
      b_word_in.n     = n_mag;
      b_word_in.p_low = a_p_ff[tdsadc_pkg::LOW_BITS-1:0];
      b_word_in.q     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (rdy_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_word_ff <= b_word_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

@@ rtl/tdsadc_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on tdsadc_pkg and the assertion macro header.
`include "tds_from_adc_temp_compensated_top_assert.svh"

module tdsadc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tdsadc_pkg::div_word_type in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output tdsadc_pkg::div_word_type out_word
);

   tdsadc_pkg::div_word_type stage_ff  [tdsadc_pkg::DIV_STAGES];
   tdsadc_pkg::div_word_type src_word  [tdsadc_pkg::DIV_STAGES];
   logic                     valid_ff  [tdsadc_pkg::DIV_STAGES];
   logic                     src_valid [tdsadc_pkg::DIV_STAGES];
   logic                     rdy       [tdsadc_pkg::DIV_STAGES+1];

   assign rdy[tdsadc_pkg::DIV_STAGES] = out_ready;
   assign in_ready = rdy[0];

   for (genvar i = 0; i < tdsadc_pkg::DIV_STAGES; i++) begin : g_stage
      localparam int BIT_POS = tdsadc_pkg::Q_BITS - 1 - i;

      logic                      dbit;
      logic [tdsadc_pkg::N_BITS:0] trial;
      tdsadc_pkg::div_word_type  word_in;

      // Each stage takes the word of the stage before it.
      if (i == 0) begin : g_head
         assign src_word[i]  = in_word;
         assign src_valid[i] = in_valid;
      end else begin : g_link
         assign src_word[i]  = stage_ff[i-1];
         assign src_valid[i] = valid_ff[i-1];
      end

      // Dividend bit shifted in: a sample bit, or zero below the sample.
      if (BIT_POS >= tdsadc_pkg::DIV_SHIFT) begin : g_sample_bit
         assign dbit = src_word[i].p_low[BIT_POS - tdsadc_pkg::DIV_SHIFT];
      end else begin : g_zero_bit
         assign dbit = 1'b0;
      end

      assign rdy[i] = !valid_ff[i] || rdy[i+1];

      // Shift, compare with the divisor, and subtract where it fits.
      always_comb begin
         trial   = {src_word[i].r, dbit};
         word_in = src_word[i];
         if (trial >= {1'b0, src_word[i].n}) begin
            word_in.r          = tdsadc_pkg::N_BITS'(trial - {1'b0, src_word[i].n});
            word_in.q[BIT_POS] = 1'b1;
         end else begin
            word_in.r = trial[tdsadc_pkg::N_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            valid_ff[i] <= src_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            stage_ff[i] <= word_in;
         end
      end
   end

   assign out_valid = valid_ff[tdsadc_pkg::DIV_STAGES-1];
   assign out_word  = stage_ff[tdsadc_pkg::DIV_STAGES-1];

   // A finished division of a positive factor leaves a remainder below the divisor.
   `TDSADC_ASSERT_IMPLY(a_rem_below_divisor, out_valid && !out_word.sat && !out_word.bad, out_word.r < out_word.n)

endmodule

@@ rtl/tdsadc_poly.sv @@
// Cubic evaluation, rounding and clamping stages, ending in the result register.
// Depends on tdsadc_pkg and the assertion macro header.
`include "tds_from_adc_temp_compensated_top_assert.svh"

module tdsadc_poly (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  tdsadc_pkg::div_word_type              in_word,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [tdsadc_pkg::TDS_BITS-1:0] out_tds,
   output tdsadc_pkg::status_type                out_status
);

   // Stage 1: voltage and its square.
   logic                                 s1_valid_ff;
   logic                                 s1_bad_ff;
   logic [tdsadc_pkg::V_BITS-1:0]        s1_v_ff;
   logic [tdsadc_pkg::V_BITS-1:0]        s1_v_in;
   logic [tdsadc_pkg::V2_BITS-1:0]       s1_v2_ff;
   logic [2*tdsadc_pkg::V_BITS-1:0]      vsq;

   // Stage 2: cube.
   logic                                 s2_valid_ff;
   logic                                 s2_bad_ff;
   logic [tdsadc_pkg::V_BITS-1:0]        s2_v_ff;
   logic [tdsadc_pkg::V2_BITS-1:0]       s2_v2_ff;
   logic [tdsadc_pkg::V3_BITS-1:0]       s2_v3_ff;
   logic [tdsadc_pkg::V2_BITS+tdsadc_pkg::V_BITS-1:0] vcube;

   // Stage 3: coefficient terms.
   logic                                 s3_valid_ff;
   logic                                 s3_bad_ff;
   logic [tdsadc_pkg::T3_BITS-1:0]       s3_t3_ff;
   logic [tdsadc_pkg::T2_BITS-1:0]       s3_t2_ff;
   logic [tdsadc_pkg::T1_BITS-1:0]       s3_t1_ff;

   // Stage 4: sum plus one half.
   logic                                 s4_valid_ff;
   logic                                 s4_bad_ff;
   logic signed [tdsadc_pkg::SUM_BITS-1:0] s4_x_ff;
   logic signed [tdsadc_pkg::SUM_BITS-1:0] s4_x_in;

   // Stage 5: division by 2^25 toward zero.
   logic                                 s5_valid_ff;
   logic                                 s5_bad_ff;
   logic signed [tdsadc_pkg::RES_BITS-1:0] s5_res_ff;
   logic signed [tdsadc_pkg::SUM_BITS-1:0] s5_y;

   // Stage 6: result register.
   logic                                 out_valid_ff;
   logic signed [tdsadc_pkg::TDS_BITS-1:0] out_tds_ff;
   logic signed [tdsadc_pkg::TDS_BITS-1:0] out_tds_in;
   tdsadc_pkg::status_type               out_status_ff;
   tdsadc_pkg::status_type               out_status_in;

   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;
   logic rdy5;
   logic rdy6;

   // Ready chain: a stage loads when it is empty or its word moves on.
   assign rdy6     = !out_valid_ff || out_ready;
   assign rdy5     = !s5_valid_ff || rdy6;
   assign rdy4     = !s4_valid_ff || rdy5;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff  <= in_valid;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) s4_valid_ff  <= s3_valid_ff;
         if (rdy5) s5_valid_ff  <= s4_valid_ff;
         if (rdy6) out_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 1: a saturated quotient becomes exactly 8.0, then square and drop 24 bits.
   assign s1_v_in = in_word.sat ? tdsadc_pkg::V_SAT : {1'b0, in_word.q};
   assign vsq     = (2 * tdsadc_pkg::V_BITS)'(s1_v_in)
                  * (2 * tdsadc_pkg::V_BITS)'(s1_v_in);

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_bad_ff <= in_word.bad;
         s1_v_ff   <= s1_v_in;
         s1_v2_ff  <= vsq[tdsadc_pkg::FRAC+tdsadc_pkg::V2_BITS-1:tdsadc_pkg::FRAC];
      end
   end

   // Stage 2: cube from the truncated square.
   assign vcube = (tdsadc_pkg::V2_BITS + tdsadc_pkg::V_BITS)'(s1_v2_ff)
                * (tdsadc_pkg::V2_BITS + tdsadc_pkg::V_BITS)'(s1_v_ff);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_bad_ff <= s1_bad_ff;
         s2_v_ff   <= s1_v_ff;
         s2_v2_ff  <= s1_v2_ff;
         s2_v3_ff  <= vcube[tdsadc_pkg::FRAC+tdsadc_pkg::V3_BITS-1:tdsadc_pkg::FRAC];
      end
   end

   // Stage 3: constant products of the three powers.
   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_bad_ff <= s2_bad_ff;
         s3_t3_ff  <= tdsadc_pkg::T3_BITS'(s2_v3_ff) * tdsadc_pkg::COEF3;
         s3_t2_ff  <= tdsadc_pkg::T2_BITS'(s2_v2_ff) * tdsadc_pkg::COEF2;
         s3_t1_ff  <= tdsadc_pkg::T1_BITS'(s2_v_ff) * tdsadc_pkg::COEF1;
      end
   end

   // Stage 4: signed sum of the terms plus one half of the final step.
   assign s4_x_in = $signed(tdsadc_pkg::SUM_BITS'(s3_t3_ff))
                  - $signed(tdsadc_pkg::SUM_BITS'(s3_t2_ff))
                  + $signed(tdsadc_pkg::SUM_BITS'(s3_t1_ff))
                  + tdsadc_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_bad_ff <= s3_bad_ff;
         s4_x_ff   <= s4_x_in;
      end
   end

   // Stage 5: a negative sum is biased up first so the shift truncates toward zero.
   assign s5_y = s4_x_ff + (s4_x_ff[tdsadc_pkg::SUM_BITS-1] ? tdsadc_pkg::TRUNC_ADJ : '0);

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_bad_ff <= s4_bad_ff;
         s5_res_ff <= s5_y[tdsadc_pkg::SUM_BITS-1:tdsadc_pkg::FRAC+1];
      end
   end

   // Stage 6: factor check and clamp into the result register.
   always_comb begin
      out_tds_in    = s5_res_ff[tdsadc_pkg::TDS_BITS-1:0];
      out_status_in = tdsadc_pkg::ST_OK;
      if (s5_bad_ff) begin
         out_tds_in    = tdsadc_pkg::TDS_LIMIT;
         out_status_in = tdsadc_pkg::ST_BAD_FACTOR;
      end else if (s5_res_ff > tdsadc_pkg::LIMIT_RES) begin
         out_tds_in    = tdsadc_pkg::TDS_LIMIT;
         out_status_in = tdsadc_pkg::ST_CLAMP;
      end else if (s5_res_ff < -tdsadc_pkg::LIMIT_RES) begin
         out_tds_in    = -tdsadc_pkg::TDS_LIMIT;
         out_status_in = tdsadc_pkg::ST_CLAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         out_tds_ff    <= out_tds_in;
         out_status_ff <= out_status_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_tds    = out_tds_ff;
   assign out_status = out_status_ff;

   // A clamped result sits exactly on one of the limits.
   `TDSADC_ASSERT_IMPLY(a_clamp_on_limit,
      out_valid_ff && out_status_ff == tdsadc_pkg::ST_CLAMP,
      out_tds_ff == tdsadc_pkg::TDS_LIMIT || out_tds_ff == -tdsadc_pkg::TDS_LIMIT)

   // The voltage is never negative, so an unclamped result is never negative.
   `TDSADC_ASSERT_IMPLY(a_ok_not_negative,
      out_valid_ff && out_status_ff == tdsadc_pkg::ST_OK,
      !out_tds_ff[tdsadc_pkg::TDS_BITS-1])

   // A bad factor that leaves stage 5 shows up as the limit with its own status.
   `TDSADC_ASSERT_NEXT(a_bad_factor_out,
      s5_valid_ff && s5_bad_ff && rdy6,
      out_valid_ff && out_status_ff == tdsadc_pkg::ST_BAD_FACTOR &&
      out_tds_ff == tdsadc_pkg::TDS_LIMIT)

endmodule

@@ rtl/tds_from_adc_temp_compensated_top.sv @@
// Top level of the TDS conversion: stream ports, configuration registers and pipeline.
// Depends on tdsadc_pkg, tdsadc_front, tdsadc_div and tdsadc_poly.
//
//   Channel  Direction  Handshake            Word contents
//   req_     in         req_tvalid/tready    adc_raw, water_temp
//   rsp_     out        rsp_tvalid/tready    tds_hundredths, status
//   csr_     in         csr_we               register index, write data
//
// One word is accepted per clock cycle while req_tready is high; its result is
// offered from the last of 35 register stages: 27 divider stages that resolve
// one quotient bit each, two front stages and six polynomial and clamp stages.
// Reset clears every valid bit and both configuration registers.
// A stalled result holds its register; upstream stages keep filling empty
// slots, so new words are taken until the pipeline is full.
module tds_from_adc_temp_compensated_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] adc_raw, [25:10] water_temp, [31:26] zero
   input  logic [tdsadc_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [20:0] tds_hundredths, [22:21] status, [23] zero
   output logic [tdsadc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [0:0]                         csr_wdata
);

   logic                                    comp_en_ff;
   logic                                    fahrenheit_ff;
   tdsadc_pkg::cfg_type                     cfg;

   logic [tdsadc_pkg::ADC_W-1:0]            req_adc_raw;
   logic signed [tdsadc_pkg::TEMP_BITS-1:0] req_water_temp;

   logic                                    front_valid;
   logic                                    front_ready;
   tdsadc_pkg::div_word_type                front_word;
   logic                                    div_valid;
   logic                                    div_ready;
   tdsadc_pkg::div_word_type                div_word;

   logic signed [tdsadc_pkg::TDS_BITS-1:0]  rsp_tds;
   tdsadc_pkg::status_type                  rsp_status;

   // Configuration registers, written one at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         comp_en_ff    <= 1'b0;
         fahrenheit_ff <= 1'b0;
      end else if (csr_we) begin
         case (tdsadc_pkg::csr_index_type'(csr_index))
            tdsadc_pkg::CSR_TEMP_COMP_EN: comp_en_ff    <= csr_wdata[0];
            tdsadc_pkg::CSR_FAHRENHEIT:   fahrenheit_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.comp_en    = comp_en_ff;
   assign cfg.fahrenheit = fahrenheit_ff;

   // Unpack the request word.
   assign req_adc_raw    = req_tdata[tdsadc_pkg::ADC_W-1:0];
   assign req_water_temp = $signed(req_tdata[tdsadc_pkg::ADC_W+tdsadc_pkg::TEMP_BITS-1:
                                             tdsadc_pkg::ADC_W]);

   tdsadc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .adc_raw    (req_adc_raw),
      .water_temp (req_water_temp),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_word   (front_word)
   );

   tdsadc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_word  (div_word)
   );

   tdsadc_poly u_poly (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_word    (div_word),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tds    (rsp_tds),
      .out_status (rsp_status)
   );

   // Pack the response word.
   assign rsp_tdata = {{tdsadc_pkg::RSP_PAD{1'b0}}, rsp_status, rsp_tds};

endmodule
